// File: rtl/core/dap_pkg.sv
// Package for the decimal argument parser: token classes, parse phases,
// configuration record and the overflow limits.
// No dependencies.
`timescale 1ns / 1ps

package dap_pkg;

   localparam int unsigned TOKQ_DEPTH = 4;
   localparam int unsigned TOKQ_AW    = $clog2(TOKQ_DEPTH);
   localparam int unsigned RSPQ_DEPTH = 2;
   localparam int unsigned RSPQ_AW    = $clog2(RSPQ_DEPTH);

   localparam logic [1:0] CSR_SIGNED_MODE  = 2'd0;
   localparam logic [1:0] CSR_MIN_VALUE    = 2'd1;
   localparam logic [1:0] CSR_MAX_VALUE    = 2'd2;
   localparam logic [1:0] CSR_TARGET_BYTES = 2'd3;

   localparam logic [3:0] SIZE_1 = 4'd1;
   localparam logic [3:0] SIZE_2 = 4'd2;
   localparam logic [3:0] SIZE_4 = 4'd4;
   localparam logic [3:0] SIZE_8 = 4'd8;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LIM_U    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_P    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_N    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] DIV_U    = LIM_U / 64'd10;
   localparam logic [63:0] DIV_P    = LIM_P / 64'd10;
   localparam logic [63:0] DIV_N    = LIM_N / 64'd10;
   localparam logic [3:0]  MOD_U    = 4'(LIM_U % 64'd10);
   localparam logic [3:0]  MOD_P    = 4'(LIM_P % 64'd10);
   localparam logic [3:0]  MOD_N    = 4'(LIM_N % 64'd10);

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_NUL,
      CLS_OTHER
   } cls_type;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGIT,
      PH_TRAIL,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      cls_type    cls;
      logic [3:0] digit;
   } tok_type;

   typedef struct packed {
      logic        signed_mode;
      logic [63:0] min_value;
      logic [63:0] max_value;
      logic [3:0]  target_bytes;
   } cfg_type;

endpackage

// File: rtl/core/dap_front.sv
// Front end: takes string bytes, classifies them and queues the tokens.
// Depends on dap_pkg.
`timescale 1ns / 1ps

module dap_front
   import dap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_ch,
   output logic       req_full,
   output logic       tok_valid,
   output tok_type    tok,
   input  logic       tok_pop
);

   tok_type              q_ff [TOKQ_DEPTH];
   logic [TOKQ_AW-1:0]   wr_ff, wr_in;
   logic [TOKQ_AW-1:0]   rd_ff, rd_in;
   logic [TOKQ_AW:0]     cnt_ff, cnt_in;
   tok_type              cls_tok;
   logic                 push;
   logic                 pop;

   always_comb begin
      cls_tok.digit = req_ch[3:0];
      if (req_ch == CH_NUL) begin
         cls_tok.cls = CLS_NUL;
      end else if (req_ch >= CH_ZERO && req_ch <= CH_NINE) begin
         cls_tok.cls = CLS_DIGIT;
      end else if (req_ch == CH_SPACE || (req_ch >= CH_TAB && req_ch <= CH_CR)) begin
         cls_tok.cls = CLS_SPACE;
      end else if (req_ch == CH_PLUS) begin
         cls_tok.cls = CLS_PLUS;
      end else if (req_ch == CH_MINUS) begin
         cls_tok.cls = CLS_MINUS;
      end else begin
         cls_tok.cls = CLS_OTHER;
      end
   end

   assign req_full  = (cnt_ff == (TOKQ_AW+1)'(TOKQ_DEPTH));
   assign tok_valid = (cnt_ff != '0);
   assign tok       = q_ff[rd_ff];
   assign push      = req_push & ~req_full;
   assign pop       = tok_pop & tok_valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (TOKQ_AW+1)'(push) - (TOKQ_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls_tok;
      end
   end

endmodule

// File: rtl/core/dap_back.sv
// Back end: parse state machine, result check stage and result queue.
// Depends on dap_pkg.
`timescale 1ns / 1ps

module dap_back
   import dap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        tok_valid,
   input  tok_type     tok,
   output logic        tok_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_ok,
   output logic [63:0] rsp_value
);

   phase_type   phase_ff, phase_in;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;

   logic        fin_valid_ff, fin_valid_in;
   logic        fin_pre_ff;
   logic [63:0] fin_v_ff;
   logic        fin_pre_in;
   logic [63:0] fin_v_in;

   logic                 rq_ok_ff  [RSPQ_DEPTH];
   logic [63:0]          rq_val_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]   rq_wr_ff, rq_wr_in;
   logic [RSPQ_AW-1:0]   rq_rd_ff, rq_rd_in;
   logic [RSPQ_AW:0]     rq_cnt_ff, rq_cnt_in;

   logic        is_nul;
   logic        step;
   logic        fin_move;
   logic        fin_ready;
   logic        rq_full;
   logic        rq_pop;
   logic [63:0] lim;
   logic [63:0] lim_div;
   logic [3:0]  lim_mod;
   logic        dig_ovf;
   logic [63:0] mag_next;
   logic        take_digit;
   logic [63:0] a_cmp, lo_cmp, hi_cmp;
   logic        size_ok;
   logic [63:0] masked;
   logic        res_ok;

   assign is_nul    = (tok.cls == CLS_NUL);
   assign rq_full   = (rq_cnt_ff == (RSPQ_AW+1)'(RSPQ_DEPTH));
   assign fin_move  = fin_valid_ff & ~rq_full;
   assign fin_ready = ~fin_valid_ff | fin_move;
   assign step      = tok_valid & (~is_nul | fin_ready);
   assign tok_pop   = step;

   always_comb begin
      if (!cfg.signed_mode) begin
         lim = LIM_U; lim_div = DIV_U; lim_mod = MOD_U;
      end else if (neg_ff) begin
         lim = LIM_N; lim_div = DIV_N; lim_mod = MOD_N;
      end else begin
         lim = LIM_P; lim_div = DIV_P; lim_mod = MOD_P;
      end
   end

   assign dig_ovf  = (mag_ff > lim_div) || (mag_ff == lim_div && tok.digit > lim_mod);
   assign mag_next = (mag_ff << 3) + (mag_ff << 1) + {60'd0, tok.digit};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_nul) begin
            phase_in = PH_LEAD;
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  case (tok.cls)
                     CLS_SPACE: phase_in = PH_LEAD;
                     CLS_PLUS:  phase_in = PH_SIGN;
                     CLS_MINUS: phase_in = cfg.signed_mode ? PH_SIGN : PH_ERROR;
                     CLS_DIGIT: phase_in = PH_DIGIT;
                     default:   phase_in = PH_ERROR;
                  endcase
               end
               PH_SIGN:  phase_in = (tok.cls == CLS_DIGIT) ? PH_DIGIT : PH_ERROR;
               PH_DIGIT: begin
                  case (tok.cls)
                     CLS_DIGIT: phase_in = PH_DIGIT;
                     CLS_SPACE: phase_in = PH_TRAIL;
                     default:   phase_in = PH_ERROR;
                  endcase
               end
               PH_TRAIL: phase_in = (tok.cls == CLS_SPACE) ? PH_TRAIL : PH_ERROR;
               default:  phase_in = PH_ERROR;
            endcase
         end
      end
   end

   // datapath outputs of the state machine
   always_comb begin
      take_digit = 1'b0;
      case (phase_ff)
         PH_LEAD, PH_SIGN, PH_DIGIT: take_digit = (tok.cls == CLS_DIGIT);
         default:                    take_digit = 1'b0;
      endcase
   end

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      if (step) begin
         if (is_nul) begin
            mag_in = '0;
            neg_in = 1'b0;
            ovf_in = 1'b0;
         end else begin
            if (phase_ff == PH_LEAD && tok.cls == CLS_MINUS && cfg.signed_mode) begin
               neg_in = 1'b1;
            end
            if (take_digit && !ovf_ff) begin
               if (dig_ovf) begin
                  ovf_in = 1'b1;
               end else begin
                  mag_in = mag_next;
               end
            end
         end
      end
   end

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (fin_move) begin
         fin_valid_in = 1'b0;
      end
      if (step && is_nul) begin
         fin_valid_in = 1'b1;
      end
      fin_pre_in = (phase_ff == PH_DIGIT || phase_ff == PH_TRAIL) && !ovf_ff
                   && !(mag_ff > lim) && !(!cfg.signed_mode && neg_ff);
      fin_v_in   = neg_ff ? (64'd0 - mag_ff) : mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         ovf_ff       <= ovf_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && is_nul) begin
         fin_pre_ff <= fin_pre_in;
         fin_v_ff   <= fin_v_in;
      end
   end

   // range and size check
   always_comb begin
      a_cmp  = fin_v_ff;
      lo_cmp = cfg.min_value;
      hi_cmp = cfg.max_value;
      if (cfg.signed_mode) begin
         a_cmp  = fin_v_ff ^ SIGN_BIT;
         lo_cmp = cfg.min_value ^ SIGN_BIT;
         hi_cmp = cfg.max_value ^ SIGN_BIT;
      end
      case (cfg.target_bytes)
         SIZE_1: begin size_ok = 1'b1; masked = {56'd0, fin_v_ff[7:0]};  end
         SIZE_2: begin size_ok = 1'b1; masked = {48'd0, fin_v_ff[15:0]}; end
         SIZE_4: begin size_ok = 1'b1; masked = {32'd0, fin_v_ff[31:0]}; end
         SIZE_8: begin size_ok = 1'b1; masked = fin_v_ff;                end
         default: begin size_ok = 1'b0; masked = '0;                     end
      endcase
      res_ok = fin_pre_ff && !(a_cmp < lo_cmp) && !(a_cmp > hi_cmp) && size_ok;
   end

   // result queue
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp_ok    = rq_ok_ff[rq_rd_ff];
   assign rsp_value = rq_val_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop & ~rsp_empty;

   always_comb begin
      rq_wr_in  = fin_move ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + (RSPQ_AW+1)'(fin_move) - (RSPQ_AW+1)'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_move) begin
         rq_ok_ff[rq_wr_ff]  <= res_ok;
         rq_val_ff[rq_wr_ff] <= res_ok ? masked : 64'd0;
      end
   end

endmodule

// File: rtl/core/decimal_argument_parser.sv
// Decimal argument parser, one byte per cycle while req_full is low. A NUL item's
// result passes the parser stage, then the range check into the result queue,
// before it is on the result ports.
// Sustained rate: one item per cycle, unless a NUL stalls on a full result queue.
// Synchronous active-high reset clears queues, parse state and registers
// (signed_mode 0, min 0, max all ones, target_bytes 8).
`timescale 1ns / 1ps

module decimal_argument_parser
   import dap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_ch,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_ok,
   output logic [63:0] rsp_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    tok_valid;
   tok_type tok;
   logic    tok_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SIGNED_MODE:  cfg_in.signed_mode  = csr_data[0];
            CSR_MIN_VALUE:    cfg_in.min_value    = csr_data;
            CSR_MAX_VALUE:    cfg_in.max_value    = csr_data;
            CSR_TARGET_BYTES: cfg_in.target_bytes = csr_data[3:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signed_mode  <= 1'b0;
         cfg_ff.min_value    <= '0;
         cfg_ff.max_value    <= '1;
         cfg_ff.target_bytes <= SIZE_8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dap_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_ch    (req_ch),
      .req_full  (req_full),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_pop   (tok_pop)
   );

   dap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_pop   (tok_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_ok    (rsp_ok),
      .rsp_value (rsp_value)
   );

endmodule

// File: test/decimal_argument_parser_checker.sv
// Checker for the decimal argument parser: watches the item, result and
// register channels, predicts each result and compares it field by field.
// Depends on dap_pkg.
`timescale 1ns / 1ps

module decimal_argument_parser_checker
   import dap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_ch,
   input  logic        req_full,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_ok,
   input  logic [63:0] rsp_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          result_count,
   output int          ok_count
);

   typedef struct packed {
      logic        ok;
      logic [63:0] value;
   } verdict_type;

   cfg_type     cfg;
   phase_type   ph;
   logic [63:0] mag;
   logic        neg;
   logic        ovf;
   verdict_type verdicts[$];
   int          fails   = 0;
   int          results = 0;
   int          oks     = 0;

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
      ok_count     = 0;
   end

   function automatic logic [63:0] mag_limit();
      if (!cfg.signed_mode) return LIM_U;
      return neg ? LIM_N : LIM_P;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic clear_string();
      ph  = PH_LEAD;
      mag = '0;
      neg = 1'b0;
      ovf = 1'b0;
   endtask

   task automatic take_digit(input logic [3:0] d);
      logic [63:0] lim;
      lim = mag_limit();
      if (ovf) return;
      if (mag > lim / 64'd10 || (mag == lim / 64'd10 && 64'(d) > lim % 64'd10))
         ovf = 1'b1;
      else
         mag = mag * 64'd10 + 64'(d);
   endtask

   function automatic verdict_type close_string();
      verdict_type r;
      logic [63:0] v, a, lo, hi;
      r = '0;
      if (!(ph == PH_DIGIT || ph == PH_TRAIL)) return r;
      if (ovf || mag > mag_limit()) return r;
      if (!cfg.signed_mode && neg) return r;
      v  = neg ? (64'd0 - mag) : mag;
      a  = v;
      lo = cfg.min_value;
      hi = cfg.max_value;
      if (cfg.signed_mode) begin
         a  ^= SIGN_BIT;
         lo ^= SIGN_BIT;
         hi ^= SIGN_BIT;
      end
      if (a < lo || a > hi) return r;
      case (cfg.target_bytes)
         SIZE_1: v = {56'd0, v[7:0]};
         SIZE_2: v = {48'd0, v[15:0]};
         SIZE_4: v = {32'd0, v[31:0]};
         SIZE_8: v = v;
         default: return r;
      endcase
      r.ok    = 1'b1;
      r.value = v;
      return r;
   endfunction

   task automatic predict_char(input logic [7:0] c);
      logic digit;
      digit = c >= CH_ZERO && c <= CH_NINE;
      if (c == CH_NUL) begin
         verdicts.push_back(close_string());
         clear_string();
         return;
      end
      case (ph)
         PH_LEAD: begin
            if (!is_blank(c)) begin
               if (c == CH_PLUS) begin
                  ph = PH_SIGN;
               end else if (c == CH_MINUS) begin
                  if (cfg.signed_mode) begin
                     neg = 1'b1;
                     ph  = PH_SIGN;
                  end else begin
                     ph = PH_ERROR;
                  end
               end else if (digit) begin
                  take_digit(4'(c - CH_ZERO));
                  ph = PH_DIGIT;
               end else begin
                  ph = PH_ERROR;
               end
            end
         end
         PH_SIGN: begin
            if (digit) begin
               take_digit(4'(c - CH_ZERO));
               ph = PH_DIGIT;
            end else begin
               ph = PH_ERROR;
            end
         end
         PH_DIGIT: begin
            if (digit) take_digit(4'(c - CH_ZERO));
            else if (is_blank(c)) ph = PH_TRAIL;
            else ph = PH_ERROR;
         end
         PH_TRAIL: begin
            if (!is_blank(c)) ph = PH_ERROR;
         end
         default: ph = PH_ERROR;
      endcase
   endtask

   task automatic note_fail(input string msg);
      fails++;
      if (fails <= 10) $display("[%0t] %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         cfg.signed_mode  = 1'b0;
         cfg.min_value    = '0;
         cfg.max_value    = LIM_U;
         cfg.target_bytes = SIZE_8;
         clear_string();
         verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIGNED_MODE:  cfg.signed_mode  = csr_data[0];
               CSR_MIN_VALUE:    cfg.min_value    = csr_data;
               CSR_MAX_VALUE:    cfg.max_value    = csr_data;
               CSR_TARGET_BYTES: cfg.target_bytes = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            results++;
            if (verdicts.size() == 0) begin
               note_fail($sformatf("unexpected result: ok %0b value %h", rsp_ok, rsp_value));
            end else begin
               want = verdicts.pop_front();
               if (rsp_ok !== want.ok)
                  note_fail($sformatf("ok: expected %0b, got %0b", want.ok, rsp_ok));
               if (rsp_value !== want.value)
                  note_fail($sformatf("value: expected %h, got %h", want.value, rsp_value));
               if (want.ok) oks++;
            end
         end
         if (req_push && !req_full) predict_char(req_ch);
      end
      fail_count   <= fails;
      pending      <= verdicts.size();
      result_count <= results;
      ok_count     <= oks;
   end

endmodule

// File: test/tb_decimal_argument_parser.sv
// Testbench top for the decimal argument parser: clock, reset, strings and
// register settings, random idling on both sides and the verdict.
// Depends on dap_pkg, decimal_argument_parser and its checker.
`timescale 1ns / 1ps

module tb_decimal_argument_parser
   import dap_pkg::*;
();

   localparam int ITEMS = 1350;
   localparam int LIMIT = 300000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic [7:0]  req_ch    = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   logic        rsp_ok;
   logic [63:0] rsp_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data  = '0;

   int fails, pending, result_count, ok_count;
   int cycles        = 0;
   int bytes_sent    = 0;
   int strings_sent  = 0;
   int settings      = 0;
   int src_idle_pct  = 27;
   int sink_idle_pct = 27;
   int hold_req      = 0;

   logic        cur_sm;
   logic [63:0] cur_lo, cur_hi;
   logic [3:0]  cur_tb;
   logic [7:0]  text[$];

   string bounds[14] = '{"18446744073709551615", "18446744073709551616",
      "9223372036854775807", "9223372036854775808", "9223372036854775809",
      "99999999999999999999", "255", "256", "65535", "65536", "4294967295",
      "4294967296", "0", "184467440737095516150"};

   decimal_argument_parser uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_ch(req_ch), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_ok(rsp_ok), .rsp_value(rsp_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   decimal_argument_parser_checker chk (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_ch(req_ch), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_ok(rsp_ok), .rsp_value(rsp_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fails), .pending(pending), .result_count(result_count),
      .ok_count(ok_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random pops, plus one long hold-off on request
   initial begin : sink_drive
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (hold_req != 0) begin
            hold_req = 0;
            hold     = 400;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_range(input int from, input int upto);
      for (int i = from; i < upto; i++) push_byte(text[i]);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   task automatic say(input string s, input bit terminate = 1'b1);
      text.delete();
      add_text(s);
      if (terminate) text.push_back(CH_NUL);
      send_range(0, text.size());
      if (terminate) strings_sent++;
   endtask

   // wait until every result is back and the pipe has drained
   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic sm, input logic [63:0] lo, input logic [63:0] hi,
                            input logic [3:0] tb);
      logic [1:0]  regs[4] = '{CSR_SIGNED_MODE, CSR_MIN_VALUE, CSR_MAX_VALUE,
                               CSR_TARGET_BYTES};
      logic [63:0] vals[4];
      vals = '{{63'd0, sm}, lo, hi, {60'd0, tb}};
      settle();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cur_sm = sm;
      cur_lo = lo;
      cur_hi = hi;
      cur_tb = tb;
      settings++;
   endtask

   task automatic add_blank(input int n);
      for (int i = 0; i < n; i++)
         text.push_back(($urandom_range(2) == 0) ? CH_SPACE
                                                : CH_TAB + 8'($urandom_range(4)));
   endtask

   task automatic build_random();
      int r, m;
      r = $urandom_range(99);
      m = $urandom_range(9);
      text.delete();
      if (r < 12) begin
         repeat ($urandom_range(6)) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         add_blank($urandom_range(2));
         case ($urandom_range(3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: ;
         endcase
         case (m)
            5: add_text($sformatf("%0d", {$urandom, $urandom}));
            6: add_text(bounds[$urandom_range(13)]);
            7: add_text($sformatf("000%0d", $urandom_range(99)));
            8: repeat ($urandom_range(1, 22)) text.push_back(CH_ZERO + 8'($urandom_range(9)));
            9: add_text($sformatf("%0d", $urandom));
            default: add_text($sformatf("%0d", $urandom_range(999)));
         endcase
         add_blank($urandom_range(2));
         if (r < 24) text.insert($urandom_range(text.size()), 8'($urandom_range(1, 255)));
      end
      text.push_back(CH_NUL);
   endtask

   task automatic random_config();
      logic        sm;
      logic [63:0] lo, hi;
      logic [3:0]  tb;
      sm = 1'($urandom_range(1));
      case ($urandom_range(9))
         0, 1: tb = SIZE_1;
         2, 3: tb = SIZE_2;
         4, 5: tb = SIZE_4;
         6, 7: tb = SIZE_8;
         default: tb = 4'($urandom_range(15));
      endcase
      case ($urandom_range(5))
         3: begin
            lo = sm ? 64'd0 - 64'($urandom_range(1000)) : 64'($urandom_range(500));
            hi = lo + 64'($urandom_range(2000));
         end
         4: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
         5: begin
            lo = 64'($urandom_range(300));
            hi = lo;
         end
         default: begin
            lo = sm ? SIGN_BIT : 64'd0;
            hi = sm ? LIM_P : LIM_U;
         end
      endcase
      configure(sm, lo, hi, tb);
   endtask

   initial begin
      int cut;
      cur_sm = 1'b0;
      cur_lo = '0;
      cur_hi = LIM_U;
      cur_tb = SIZE_8;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings first
      say("0");
      say("18446744073709551615");
      say("18446744073709551616");
      say("");
      say("+");
      say(" \t\n42 \r");
      say("-5");
      say("1x2");
      say("12 3");
      text.delete();
      text.push_back(8'hFF);
      text.push_back(CH_NUL);
      send_range(0, 2);
      strings_sent++;

      configure(1'b1, SIGN_BIT, LIM_P, SIZE_8);
      say("-9223372036854775808");
      say("9223372036854775808");
      say("-9223372036854775809");
      say("\v\f-1");
      configure(1'b1, 64'd0 - 64'd10, 64'd10, SIZE_2);
      say("-10");
      say("11");
      configure(1'b1, SIGN_BIT, LIM_P, 4'd0);
      say("7");
      configure(1'b0, LIM_U, LIM_U, SIZE_1);
      say("18446744073709551615");
      say("+18446744073709551614");

      // sign taken in signed mode, then the mode drops back mid-string; then the reverse switch
      configure(1'b1, SIGN_BIT, LIM_P, SIZE_8);
      say("-12", 1'b0);
      configure(1'b0, 64'd0, LIM_U, SIZE_8);
      say("3");
      configure(1'b0, 64'd0, LIM_U, SIZE_4);
      say("9223372036854775807", 1'b0);
      configure(1'b1, SIGN_BIT, LIM_P, SIZE_4);
      say("0");

      // random: starts with the result side held off, with a stretch of no idling on either side
      hold_req = 1;
      src_idle_pct = 0;
      while (bytes_sent < ITEMS) begin
         if (bytes_sent > 250 && bytes_sent < 650) begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end else begin
            src_idle_pct  = 27;
            sink_idle_pct = 27;
         end
         build_random();
         if (strings_sent % 40 == 39) begin
            if ($urandom_range(3) == 0) begin
               cut = $urandom_range(text.size() - 1);
               send_range(0, cut);
               configure(~cur_sm, cur_lo, cur_hi, cur_tb);
               send_range(cut, text.size());
               strings_sent++;
               continue;
            end
            random_config();
         end
         send_range(0, text.size());
         strings_sent++;
      end

      settle();
      repeat (12) @(posedge clock);
      $display("%0d bytes in %0d strings under %0d register settings", bytes_sent,
               strings_sent, settings);
      $display("%0d results checked, %0d accepted, %0d failures", result_count, ok_count,
               fails);
      if (fails == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
